// ----- rtl/sffl_pkg.sv -----
// Shared types and constants for the substring first/last finder.
// No dependencies; imported by every module of the block.
`default_nettype none

package sffl_pkg;

  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned TEXT_MAX    = 65536;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IDX_W       = $clog2(PATTERN_MAX);
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 40;

  // Register indices of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOW    = 2'd1,
    CFG_PATTERN_HIGH   = 2'd2
  } cfg_reg_e;

  // Byte 0 of the window is the newest text byte; byte 0 of the pattern is its first.
  typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_t;

  // Status of the item held in the window stage.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             counted;
    logic             overflow;
    logic [CNT_W-1:0] bytes_seen;
  } win_stat_t;

endpackage

`default_nettype wire

// ----- rtl/substring_first_last_finder_unit.sv -----
// The final byte is registered in the window stage, and its result then in the result register for the master side.
// Throughput: one text byte per cycle while no result waits; the window compare of all pattern lengths is done in
// parallel between the window register and the result register.
// Both stages advance together whenever the result register is empty or being taken.
// Reset clears the configuration to zero and starts a fresh text; no clearing pass is needed.
`default_nettype none

module substring_first_last_finder_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [sffl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [sffl_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: text_byte [7:0]
  input  wire logic [sffl_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  wire logic                                s_axis_tlast_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // tdata: match_found [0], first_start [16:1], last_start [32:17],
  //        ends_with_pattern [33], length_overflow [34], zero [39:35]
  output logic [sffl_pkg::OUT_DATA_W-1:0]          m_axis_tdata_o
);
  import sffl_pkg::*;

  logic             adv;
  win_t             win;
  win_stat_t        stat;
  win_t             pat_q;
  logic [LEN_W-1:0] pat_len_q;
  logic             hit;
  logic             rec;
  logic [POS_W-1:0] start;
  logic             seen_q, seen_d;
  logic [POS_W-1:0] first_q, first_d;
  logic [POS_W-1:0] last_q, last_d;
  logic             out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      pat_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN_LENGTH: pat_len_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_PATTERN_LOW:    pat_q[7:0] <= cfg_wdata_i;
        CFG_PATTERN_HIGH:   pat_q[15:8] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sffl_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .in_valid_i   (s_axis_tvalid_i),
    .text_byte_i  (s_axis_tdata_i[BYTE_W-1:0]),
    .final_byte_i (s_axis_tlast_i),
    .win_o        (win),
    .stat_o       (stat)
  );

  sffl_window_cmp u_cmp (
    .win_i   (win),
    .pat_i   (pat_q),
    .len_i   (pat_len_q),
    .avail_i (stat.bytes_seen),
    .hit_o   (hit)
  );

  // Occurrences completed by bytes beyond the countable length are not recorded.
  always_comb begin
    rec     = hit && stat.counted;
    start   = POS_W'(stat.bytes_seen - {{(CNT_W-LEN_W){1'b0}}, pat_len_q});
    seen_d  = seen_q | rec;
    first_d = (rec && !seen_q) ? start : first_q;
    last_d  = rec ? start : last_q;
    out_data_d = '0;
    out_data_d[0]     = seen_d;
    out_data_d[16:1]  = seen_d ? first_d : '0;
    out_data_d[32:17] = seen_d ? last_d : '0;
    out_data_d[33]    = hit;
    out_data_d[34]    = stat.overflow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= stat.valid && stat.last;
      if (stat.valid) begin
        seen_q <= stat.last ? 1'b0 : seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && stat.valid) begin
      first_q <= first_d;
      last_q  <= last_d;
      if (stat.last) begin
        out_data_q <= out_data_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTH
  // A new result only follows a final byte held in the window stage.
  a_result_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(stat.valid && stat.last))
    else $error("result produced without a final byte");

  // Without a match both start indices read as zero.
  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[32:1] == '0))
    else $error("start index reported without a match");

  // The first occurrence never starts after the last one.
  a_first_not_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> (m_axis_tdata_o[16:1] <= m_axis_tdata_o[32:17]))
    else $error("first occurrence after last occurrence");
`endif

endmodule

`default_nettype wire

// ----- rtl/sffl_window.sv -----
// Input stage: recent-byte window, saturating position counter and overflow flag.
// Depends on sffl_pkg.
`default_nettype none

module sffl_window (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         text_byte_i,
  input  wire logic               final_byte_i,
  output sffl_pkg::win_t          win_o,
  output sffl_pkg::win_stat_t     stat_o
);
  import sffl_pkg::*;

  win_t             win_q, win_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_base;
  logic             ovf_q, ovf_d;
  logic             valid_q;
  logic             last_q;
  logic             counted_q, counted;
  logic             accept;

  assign accept = adv_i && in_valid_i;

  // Old bytes need no clearing at the start of a text: the counter bounds the compare.
  always_comb begin
    cnt_base = last_q ? '0 : cnt_q;
    counted  = cnt_base < CNT_W'(TEXT_MAX);
    cnt_d    = counted ? cnt_base + CNT_W'(1) : cnt_base;
    ovf_d    = (last_q ? 1'b0 : ovf_q) | ~counted;
    win_d    = {win_q[PATTERN_MAX-2:0], text_byte_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      last_q    <= 1'b1;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      counted_q <= 1'b0;
    end else begin
      if (adv_i) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        last_q    <= final_byte_i;
        cnt_q     <= cnt_d;
        ovf_q     <= ovf_d;
        counted_q <= counted;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  assign win_o = win_q;
  assign stat_o = '{valid: valid_q, last: last_q, counted: counted_q,
                    overflow: ovf_q, bytes_seen: cnt_q};

endmodule

`default_nettype wire

// ----- rtl/sffl_window_cmp.sv -----
// Parallel window compare: does the pattern end at the newest byte of the window?
// Depends on sffl_pkg.
`default_nettype none

module sffl_window_cmp (
  input  wire sffl_pkg::win_t             win_i,
  input  wire sffl_pkg::win_t             pat_i,
  input  wire logic [sffl_pkg::LEN_W-1:0] len_i,
  input  wire logic [sffl_pkg::CNT_W-1:0] avail_i,
  output logic                            hit_o
);
  import sffl_pkg::*;

  logic [PATTERN_MAX-1:0] len_hit;
  logic [LEN_W-1:0]       len_dec;

  // One comparator row per possible pattern length; pattern byte j meets window byte l-1-j.
  for (genvar l = 1; l <= PATTERN_MAX; l++) begin : g_len
    logic [l-1:0] eq;
    for (genvar j = 0; j < l; j++) begin : g_byte
      assign eq[j] = (win_i[l-1-j] == pat_i[j]);
    end
    assign len_hit[l-1] = &eq;
  end

  assign len_dec = len_i - LEN_W'(1);

  assign hit_o = (len_i != '0)
              && (len_i <= LEN_W'(PATTERN_MAX))
              && ({{(CNT_W-LEN_W){1'b0}}, len_i} <= avail_i)
              && len_hit[len_dec[IDX_W-1:0]];

endmodule

`default_nettype wire

// ----- tb/sv/sffl_result_checker.sv -----
// Scoreboard for the substring first/last finder: follows the configuration port and both
// stream channels, predicts every search report and compares it field by field.
// Depends on sffl_pkg for widths, the window type and the register indices.
module sffl_result_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sffl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sffl_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                text_valid_i,
  input  logic                                text_ready_i,
  // text_byte [7:0]
  input  logic [sffl_pkg::IN_DATA_W-1:0]      text_data_i,
  input  logic                                text_last_i,
  input  logic                                report_valid_i,
  input  logic                                report_ready_i,
  // match_found [0], first_start [16:1], last_start [32:17],
  // ends_with_pattern [33], length_overflow [34], zero [39:35]
  input  logic [sffl_pkg::OUT_DATA_W-1:0]     report_data_i,
  output int unsigned                         failures_o,
  output int unsigned                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sffl_pkg::*;

  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] first_start;
    logic [POS_W-1:0] last_start;
    logic             ends_with_pattern;
    logic             length_overflow;
  } search_report_t;

  logic [LEN_W-1:0] pat_len;
  logic [CFG_W-1:0] pat_low;
  logic [CFG_W-1:0] pat_high;
  win_t             recent;
  logic [CNT_W-1:0] text_count;
  logic             seen_match;
  logic             overflowed;
  logic [POS_W-1:0] first_pos;
  logic [POS_W-1:0] latest_pos;
  search_report_t   expected_reports[$];

  function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned k);
    if (k < 8) return pat_low[8*k +: 8];
    if (k < 16) return pat_high[8*(k-8) +: 8];
    return '0;
  endfunction

  // True when the configured pattern ends at the newest byte of the window.
  function automatic logic window_hit();
    int unsigned len;
    len = 32'(pat_len);
    if (len == 0 || len > PATTERN_MAX || len > text_count) return 1'b0;
    for (int unsigned j = 0; j < len; j++)
      if (recent[len-1-j] != pattern_byte(j)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_text();
    recent     = '0;
    text_count = '0;
    seen_match = 1'b0;
    overflowed = 1'b0;
    first_pos  = '0;
    latest_pos = '0;
  endfunction

  function automatic void scan_text_byte(input logic [BYTE_W-1:0] b, input logic fin);
    logic             counted;
    logic             hit;
    logic [CNT_W-1:0] start;
    search_report_t   rep;
    recent  = {recent[PATTERN_MAX-2:0], b};
    counted = (text_count < TEXT_MAX);
    if (counted) text_count = text_count + CNT_W'(1);
    else overflowed = 1'b1;
    // Occurrences completed after the counter has saturated are not recorded.
    hit = window_hit();
    if (hit && counted) begin
      start = text_count - CNT_W'(pat_len);
      if (!seen_match) first_pos = start[POS_W-1:0];
      latest_pos = start[POS_W-1:0];
      seen_match = 1'b1;
    end
    if (fin) begin
      rep.match_found       = seen_match;
      rep.first_start       = seen_match ? first_pos : '0;
      rep.last_start        = seen_match ? latest_pos : '0;
      rep.ends_with_pattern = hit;
      rep.length_overflow   = overflowed;
      expected_reports.push_back(rep);
      clear_text();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
                                 input logic [OUT_DATA_W-1:0] want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    failures_o++;
  endtask

  task automatic compare_report(input logic [OUT_DATA_W-1:0] data);
    search_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("report with nothing outstanding", data, '0);
      return;
    end
    want = expected_reports.pop_front();
    if (data[0] !== want.match_found)
      report_mismatch("match_found", OUT_DATA_W'(data[0]), OUT_DATA_W'(want.match_found));
    if (data[16:1] !== want.first_start)
      report_mismatch("first_start", OUT_DATA_W'(data[16:1]), OUT_DATA_W'(want.first_start));
    if (data[32:17] !== want.last_start)
      report_mismatch("last_start", OUT_DATA_W'(data[32:17]), OUT_DATA_W'(want.last_start));
    if (data[33] !== want.ends_with_pattern)
      report_mismatch("ends_with_pattern", OUT_DATA_W'(data[33]),
                      OUT_DATA_W'(want.ends_with_pattern));
    if (data[34] !== want.length_overflow)
      report_mismatch("length_overflow", OUT_DATA_W'(data[34]),
                      OUT_DATA_W'(want.length_overflow));
    if (data[OUT_DATA_W-1:35] !== '0)
      report_mismatch("padding bits", OUT_DATA_W'(data[OUT_DATA_W-1:35]), '0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len    = '0;
      pat_low    = '0;
      pat_high   = '0;
      failures_o = 0;
      clear_text();
      expected_reports.delete();
    end else begin
      if (report_valid_i && report_ready_i) compare_report(report_data_i);
      if (text_valid_i && text_ready_i) scan_text_byte(text_data_i, text_last_i);
      // A register write only affects bytes that arrive after it.
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_PATTERN_LENGTH: pat_len = cfg_wdata_i[LEN_W-1:0];
          CFG_PATTERN_LOW:    pat_low = cfg_wdata_i;
          CFG_PATTERN_HIGH:   pat_high = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_reports.size();
  end

endmodule

// ----- tb/sv/substring_first_last_finder_unit_tb.sv -----
// Top of the substring finder testbench: clock, reset, register writes, text stimulus and
// result back-pressure around the block; checking is left to sffl_result_checker.
// Depends on sffl_pkg, substring_first_last_finder_unit and sffl_result_checker.
module substring_first_last_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sffl_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 340;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int unsigned           failures;
  int unsigned           pending;

  bit                    tx_gaps_on = 1'b1;
  bit                    hold_request = 1'b0;
  bit                    hold_active = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  substring_first_last_finder_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  sffl_result_checker report_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .text_valid_i   (s_axis_tvalid),
    .text_ready_i   (s_axis_tready),
    .text_data_i    (s_axis_tdata),
    .text_last_i    (s_axis_tlast),
    .report_valid_i (m_axis_tvalid),
    .report_ready_i (m_axis_tready),
    .report_data_i  (m_axis_tdata),
    .failures_o     (failures),
    .pending_o      (pending)
  );

  // Mostly no delay, often a short one, now and then a long one.
  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_char(input bit narrow);
    if (narrow) return $urandom_range(0, 1) ? 8'h61 : 8'h62;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pattern(input logic [LEN_W-1:0] len, input win_t pat);
    write_reg(CFG_PATTERN_LENGTH, CFG_W'(len));
    write_reg(CFG_PATTERN_LOW, pat[7:0]);
    write_reg(CFG_PATTERN_HIGH, pat[15:8]);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = tx_gaps_on ? pick_delay() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_text(input logic [7:0] txt[$]);
    foreach (txt[i]) push_byte(txt[i], i == txt.size() - 1);
  endtask

  // Stop offering, wait for every outstanding report and let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : receiver
    int unsigned stall;
    int unsigned steady;
    steady = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_active = 1'b0;
      end else begin
        if (steady > 0) begin
          steady--;
          stall = 0;
        end else begin
          if ($urandom_range(0, 19) == 0) steady = $urandom_range(20, 80);
          stall = pick_delay();
        end
        if (stall == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    win_t              pat;
    logic [7:0]        txt[$];
    logic [LEN_W-1:0]  plen;
    int unsigned       r;
    int unsigned       tlen;
    int unsigned       used;
    int unsigned       pos;
    int unsigned       texts;
    int unsigned       random_sent;
    bit                narrow;
    random_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Empty pattern straight after reset: never a match.
    txt = '{8'hFF};
    send_text(txt);
    settle();

    // Single-character search with occurrences at both ends.
    pat = '0;
    pat[0] = 8'h61;
    set_pattern(LEN_W'(1), pat);
    txt = '{8'h61, 8'h62, 8'h61};
    send_text(txt);
    settle();

    // Full-width pattern with extreme byte values, text equal to the pattern.
    pat = {8'h99, 8'hCC, 8'h33, 8'hF0, 8'h0F, 8'h40, 8'h30, 8'h20,
           8'h10, 8'hAA, 8'h55, 8'h7F, 8'h80, 8'h01, 8'hFF, 8'h00};
    set_pattern(LEN_W'(16), pat);
    txt.delete();
    for (int k = 0; k < PATTERN_MAX; k++) txt.push_back(pat[k]);
    send_text(txt);
    settle();

    // Pattern longer than the text.
    pat = '0;
    pat[0] = 8'h61;
    pat[1] = 8'h62;
    pat[2] = 8'h63;
    set_pattern(LEN_W'(3), pat);
    txt = '{8'h61, 8'h62};
    send_text(txt);
    settle();

    // Length beyond the pattern store, all-ones pattern registers.
    pat = '1;
    set_pattern(LEN_W'(31), pat);
    txt = '{8'hFF, 8'hFF};
    send_text(txt);
    settle();

    // Keep offering one-byte texts while the receiver holds off, so the input stalls.
    tx_gaps_on = 1'b0;
    hold_request = 1'b1;
    while (!hold_active) @(negedge clk);
    repeat (30) begin
      txt = '{pick_char(1'($urandom_range(0, 1)))};
      send_text(txt);
    end
    settle();
    tx_gaps_on = 1'b1;

    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) plen = '0;
      else if (r < 20) plen = LEN_W'(PATTERN_MAX);
      else if (r < 28) plen = LEN_W'($urandom_range(17, 31));
      else if (r < 45) plen = LEN_W'($urandom_range(5, 15));
      else plen = LEN_W'($urandom_range(1, 4));
      narrow = ($urandom_range(0, 9) < 7);
      for (int k = 0; k < PATTERN_MAX; k++) pat[k] = pick_char(narrow);
      set_pattern(plen, pat);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      texts = $urandom_range(1, 6);
      repeat (texts) begin
        r = $urandom_range(0, 99);
        tlen = (r < 70) ? $urandom_range(1, 20) : (r < 95) ? $urandom_range(21, 64) : 1;
        txt.delete();
        repeat (tlen) txt.push_back(pick_char(narrow));
        used = (plen > LEN_W'(PATTERN_MAX)) ? 0 : 32'(plen);
        // Plant the pattern in half of the texts that can hold it, often at the very end.
        if (used != 0 && used <= tlen && $urandom_range(0, 9) < 5) begin
          pos = ($urandom_range(0, 2) == 0) ? tlen - used : $urandom_range(0, tlen - used);
          for (int k = 0; k < used; k++) txt[pos + k] = pat[k];
        end
        send_text(txt);
        random_sent += tlen;
      end
      settle();
    end

    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sffl_pkg.sv
rtl/sffl_window.sv
rtl/sffl_window_cmp.sv
rtl/substring_first_last_finder_unit.sv
tb/sv/sffl_result_checker.sv
tb/sv/substring_first_last_finder_unit_tb.sv
